FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by csr_sparse_matvec.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// a at an edge implies b at the same edge
`define ASSERT_IMPLY(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed: a |-> b");

// a at an edge implies b at the next edge
`define ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed: a |=> b");

`else

`define ASSERT_IMPLY(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)

`endif

`endif

FILE: design/csm_pkg.sv
// ----------------------------------------------------------------------------
// csm_pkg
// Types and constants of the sparse matrix-vector multiplier.
// ----------------------------------------------------------------------------
package csm_pkg;

   localparam int INDEX_W   = 10;
   localparam int VALUE_W   = 32;
   localparam int SUM_W     = 64;
   localparam int ROW_W     = 16;
   localparam int MAX_INDEX = 2 ** INDEX_W;

   localparam logic signed [SUM_W-1:0] ACC_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] ACC_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   typedef enum logic [1:0] {
      CMD_LOAD      = 2'd0,
      CMD_NONZERO   = 2'd1,
      CMD_EMPTY_ROW = 2'd2
   } cmd_type;

   typedef struct packed {
      logic [1:0]                command;
      logic [INDEX_W-1:0]        index;
      logic signed [VALUE_W-1:0] operand_value;
      logic                      row_end;
      logic                      last_row;
   } req_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] row_sum;
      logic [ROW_W-1:0]        row_number;
      logic                    final_row;
      logic                    saturated;
   } rsp_type;

   // stage 2 control: what the accumulate stage does with its item
   typedef struct packed {
      logic valid;
      logic ends_row;
      logic last_row;
   } acc_ctl_type;

endpackage

FILE: design/csm_vec_store.sv
// ----------------------------------------------------------------------------
// csm_vec_store
// Vector element store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module csm_vec_store #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [ADDR_W-1:0]          wr_addr,
   input  logic [csm_pkg::VALUE_W-1:0] wr_data,
   input  logic                       rd_en,
   input  logic [ADDR_W-1:0]          rd_addr,
   output logic [csm_pkg::VALUE_W-1:0] rd_data
);

   logic [csm_pkg::VALUE_W-1:0] mem [DEPTH];
   logic [csm_pkg::VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // hold read data until the next read so a stalled pipeline keeps its operand
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/csr_sparse_matvec.sv
// ----------------------------------------------------------------------------
// csr_sparse_matvec
// Streaming sparse matrix-vector product y = Sx, matrix in compressed rows.
// ----------------------------------------------------------------------------
// Input channel req_*: one transaction per command. A load writes an element
// of x into the vector store, a nonzero multiplies its Q16.16 value by the
// stored element at its column and adds the Q32.32 product to the row
// accumulator, an empty row stands for a row with no nonzeros. The item that
// ends a row produces one rsp_* transaction with the saturated row sum, the
// row number, the last-row mark and the clip flag of that row.
// A row result follows its ending item through the store read, the multiply
// and the accumulate into the output register, each registered in turn.
// Throughput: one item per cycle unless the receiver stalls, set by the single
// multiply-accumulate; in-range loads write the store, in-range nonzeros read it.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and req_ready drops; it resumes in the cycle rsp_ready returns.
// Reset clears the accumulator, row counter, clip flag and all valid bits.
// The vector store is not cleared: elements must be loaded before use.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module csr_sparse_matvec #(
   parameter int VECTOR_DEPTH = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  csm_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output csm_pkg::rsp_type rsp_payload
);

   // entries above the index range can never be addressed
   localparam int STORE_DEPTH = (VECTOR_DEPTH < csm_pkg::MAX_INDEX) ?
                                VECTOR_DEPTH : csm_pkg::MAX_INDEX;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   logic advance;
   logic req_accept;
   logic in_range;
   logic [ADDR_W-1:0] store_addr;
   logic [csm_pkg::VALUE_W-1:0] rd_data;

   // stage 1: operand fetch
   logic                              s1_valid_ff, s1_valid_in;
   logic                              s1_nonzero_ff;
   logic                              s1_in_range_ff;
   csm_pkg::acc_ctl_type              s1_ctl_ff;
   logic signed [csm_pkg::VALUE_W-1:0] s1_value_ff;

   // stage 2: accumulate
   csm_pkg::acc_ctl_type              s2_ctl_ff, s2_ctl_in;
   logic signed [csm_pkg::SUM_W-1:0]  s2_prod_ff, s2_prod_in;

   logic signed [csm_pkg::VALUE_W-1:0] vec_operand;
   logic signed [csm_pkg::SUM_W-1:0]   acc_ff, acc_in;
   logic signed [csm_pkg::SUM_W-1:0]   sum_raw, sum_sat;
   logic                               overflow;
   logic                               clip_ff, clip_in;
   logic [csm_pkg::ROW_W-1:0]          row_cnt_ff, row_cnt_in;
   logic                               emit;

   logic             rsp_valid_ff, rsp_valid_in;
   csm_pkg::rsp_type rsp_ff, rsp_in;

   assign advance    = !rsp_valid_ff || rsp_ready;
   assign req_ready  = advance;
   assign req_accept = req_valid && advance;
   assign in_range   = 32'(req_payload.index) < VECTOR_DEPTH;
   assign store_addr = req_payload.index[ADDR_W-1:0];

   csm_vec_store #(
      .DEPTH  (STORE_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_vec_store (
      .clock   (clock),
      .wr_en   (req_accept && in_range &&
                req_payload.command == csm_pkg::CMD_LOAD),
      .wr_addr (store_addr),
      .wr_data (req_payload.operand_value),
      .rd_en   (req_accept && in_range &&
                req_payload.command == csm_pkg::CMD_NONZERO),
      .rd_addr (store_addr),
      .rd_data (rd_data)
   );

   // ---- stage 1 ----
   always_comb begin
      s1_valid_in = 1'b0;
      case (req_payload.command)
         csm_pkg::CMD_NONZERO,
         csm_pkg::CMD_EMPTY_ROW: s1_valid_in = 1'b1;
         default:                s1_valid_in = 1'b0;   // loads and the unused code
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid && s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_nonzero_ff     <= req_payload.command == csm_pkg::CMD_NONZERO;
         s1_in_range_ff    <= in_range;
         s1_value_ff       <= req_payload.operand_value;
         s1_ctl_ff.valid   <= 1'b1;
         s1_ctl_ff.ends_row <= (req_payload.command == csm_pkg::CMD_EMPTY_ROW) ||
                               req_payload.row_end;
         s1_ctl_ff.last_row <= req_payload.last_row;
      end
   end

   // out-of-range columns and empty rows contribute nothing
   assign vec_operand = (s1_nonzero_ff && s1_in_range_ff) ? $signed(rd_data) : '0;

   always_comb begin
      s2_prod_in          = s1_value_ff * vec_operand;
      s2_ctl_in           = s1_ctl_ff;
      s2_ctl_in.valid     = s1_valid_ff;
   end

   // ---- stage 2 ----
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctl_ff <= '0;
      end else if (advance) begin
         s2_ctl_ff <= s2_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_prod_ff <= s2_prod_in;
      end
   end

   always_comb begin
      sum_raw  = acc_ff + s2_prod_ff;
      overflow = (acc_ff[csm_pkg::SUM_W-1] == s2_prod_ff[csm_pkg::SUM_W-1]) &&
                 (sum_raw[csm_pkg::SUM_W-1] != acc_ff[csm_pkg::SUM_W-1]);
      sum_sat  = overflow ? (acc_ff[csm_pkg::SUM_W-1] ? csm_pkg::ACC_MIN
                                                       : csm_pkg::ACC_MAX)
                          : sum_raw;
      emit     = advance && s2_ctl_ff.valid && s2_ctl_ff.ends_row;

      acc_in     = acc_ff;
      clip_in    = clip_ff;
      row_cnt_in = row_cnt_ff;
      if (advance && s2_ctl_ff.valid) begin
         if (s2_ctl_ff.ends_row) begin
            acc_in     = '0;
            clip_in    = 1'b0;
            row_cnt_in = s2_ctl_ff.last_row ? '0 : row_cnt_ff + 1'b1;
         end else begin
            acc_in  = sum_sat;
            clip_in = clip_ff || overflow;
         end
      end

      rsp_in.row_sum    = sum_sat;
      rsp_in.row_number = row_cnt_ff;
      rsp_in.final_row  = s2_ctl_ff.last_row;
      rsp_in.saturated  = clip_ff || overflow;

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         clip_ff      <= 1'b0;
         row_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         clip_ff      <= clip_in;
         row_cnt_ff   <= row_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // ---- assertions ----
   `ASSERT_NEXT(a_row_clears_acc, clock, reset, emit, (acc_ff == '0) && !clip_ff)
   `ASSERT_NEXT(a_emit_fills_rsp, clock, reset, emit, rsp_valid_ff)
   `ASSERT_NEXT(a_last_row_restarts, clock, reset, emit && s2_ctl_ff.last_row,
                row_cnt_ff == '0)
   `ASSERT_IMPLY(a_no_emit_into_full, clock, reset, rsp_valid_ff && !rsp_ready, !emit)

endmodule

FILE: tb/csr_sparse_matvec_test.sv
// ----------------------------------------------------------------------------
// csr_sparse_matvec_test
// Self-checking testbench for the streaming sparse matrix-vector multiplier.
// ----------------------------------------------------------------------------
// Streams vector loads, nonzeros and empty rows into the block and predicts
// every row result in step with the accepted transactions. Directed tests
// cover the field extremes, saturation on both sides, row framing and the
// reserved command. Random tests then stream whole matrices with random
// content and some noise under three sender/receiver stall mixes.
// ----------------------------------------------------------------------------
module csr_sparse_matvec_test;

   localparam logic [1:0] CMD_RESERVED = 2'd3;
   localparam logic [31:0] Q_MIN = 32'h8000_0000;
   localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] Q_ONE = 32'h0001_0000;
   localparam int          SUM_MSB = csm_pkg::SUM_W - 1;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   csm_pkg::req_type req_payload = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   csm_pkg::rsp_type rsp_payload;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int error_count = 0;
   int items_sent = 0;

   // predicted block state
   logic [csm_pkg::VALUE_W-1:0]      x_mem [csm_pkg::MAX_INDEX];
   logic signed [csm_pkg::SUM_W-1:0] row_acc = '0;
   logic [csm_pkg::ROW_W-1:0]        row_idx = '0;
   bit                               row_clipped = 1'b0;
   int                               loaded_cols[$];
   bit                               col_loaded [csm_pkg::MAX_INDEX];
   csm_pkg::rsp_type                 pending_row_sums[$];

   csr_sparse_matvec dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   function automatic csm_pkg::req_type make_req(input logic [1:0] cmd,
                                                 input int unsigned idx,
                                                 input logic [31:0] val, input bit re,
                                                 input bit lr);
      csm_pkg::req_type r;
      r.command       = cmd;
      r.index         = idx[csm_pkg::INDEX_W-1:0];
      r.operand_value = val;
      r.row_end       = re;
      r.last_row      = lr;
      return r;
   endfunction

   // Close the row: queue its sum, advance the row number (zero after last).
   function automatic void close_row(input bit lr);
      csm_pkg::rsp_type r;
      r.row_sum    = row_acc;
      r.row_number = row_idx;
      r.final_row  = lr;
      r.saturated  = row_clipped;
      pending_row_sums.push_back(r);
      row_acc     = '0;
      row_clipped = 1'b0;
      row_idx     = lr ? '0 : row_idx + 1'b1;
   endfunction

   function automatic void predict_row_sums(input csm_pkg::req_type item);
      logic signed [csm_pkg::SUM_W-1:0] a;
      logic signed [csm_pkg::SUM_W-1:0] b;
      logic signed [csm_pkg::SUM_W-1:0] prod;
      logic signed [csm_pkg::SUM_W-1:0] sum;
      case (item.command)
         csm_pkg::CMD_LOAD: begin
            x_mem[item.index] = item.operand_value;
            if (!col_loaded[item.index]) begin
               col_loaded[item.index] = 1'b1;
               loaded_cols.push_back(int'(item.index));
            end
         end
         csm_pkg::CMD_NONZERO: begin
            a    = item.operand_value;
            b    = $signed(x_mem[item.index]);
            prod = a * b;
            sum  = row_acc + prod;
            // clip when both addends share a sign that the sum lost
            if (row_acc[SUM_MSB] == prod[SUM_MSB] && sum[SUM_MSB] != row_acc[SUM_MSB]) begin
               sum         = row_acc[SUM_MSB] ? csm_pkg::ACC_MIN : csm_pkg::ACC_MAX;
               row_clipped = 1'b1;
            end
            row_acc = sum;
            if (item.row_end)
               close_row(item.last_row);
         end
         csm_pkg::CMD_EMPTY_ROW: close_row(item.last_row);
         default: ;
      endcase
   endfunction

   task automatic send_item(input csm_pkg::req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      predict_row_sums(item);
      if (item.command != CMD_RESERVED)
         items_sent++;
   endtask

   // Hold off the sender until every pending row result has arrived.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_row_sums.size() != 0)
         @(posedge clock);
   endtask

   always @(posedge clock) begin : row_checker
      csm_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_row_sums.size() == 0) begin
            $error("row result with none pending: row_number %0d", rsp_payload.row_number);
            error_count++;
         end else begin
            want = pending_row_sums.pop_front();
            if (rsp_payload.row_sum !== want.row_sum) begin
               $error("row_sum: expected %0d, actual %0d", want.row_sum, rsp_payload.row_sum);
               error_count++;
            end
            if (rsp_payload.row_number !== want.row_number) begin
               $error("row_number: expected %0d, actual %0d",
                      want.row_number, rsp_payload.row_number);
               error_count++;
            end
            if (rsp_payload.final_row !== want.final_row) begin
               $error("final_row: expected %0b, actual %0b",
                      want.final_row, rsp_payload.final_row);
               error_count++;
            end
            if (rsp_payload.saturated !== want.saturated) begin
               $error("saturated: expected %0b, actual %0b",
                      want.saturated, rsp_payload.saturated);
               error_count++;
            end
         end
      end
   end

   function automatic logic [31:0] rand_operand();
      logic [31:0] v;
      case ($urandom_range(0, 7))
         0: v = Q_MIN;
         1: v = Q_MAX;
         2: v = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
         3, 4: begin
            v = $urandom_range(0, 32'h3_FFFF);
            if ($urandom_range(0, 1))
               v = -v;
         end
         default: v = $urandom;
      endcase
      return v;
   endfunction

   function automatic int unsigned pick_column();
      return loaded_cols[$urandom_range(0, loaded_cols.size() - 1)];
   endfunction

   // Loads at both ends of the store; row flags on a load must be ignored.
   task automatic test_vector_loads();
      send_item(make_req(csm_pkg::CMD_LOAD, 0, Q_MIN, 1'b1, 1'b1));
      send_item(make_req(csm_pkg::CMD_LOAD, csm_pkg::MAX_INDEX - 1, Q_MAX, 1'b0, 1'b0));
      send_item(make_req(csm_pkg::CMD_LOAD, 1, 32'hFFFF_FFFF, 1'b1, 1'b0));
      send_item(make_req(csm_pkg::CMD_LOAD, 2, 32'h0, 1'b0, 1'b1));
      send_item(make_req(csm_pkg::CMD_LOAD, 10'h2AA, 32'h5555_5555, 1'b0, 1'b0));
      send_item(make_req(csm_pkg::CMD_LOAD, 10'h155, 32'hAAAA_AAAA, 1'b0, 1'b0));
   endtask

   // Clip high, fall back inside the row, then clip low on a final row.
   task automatic test_saturation();
      send_item(make_req(csm_pkg::CMD_NONZERO, 0, Q_MIN, 1'b0, 1'b0));
      send_item(make_req(csm_pkg::CMD_NONZERO, 0, Q_MIN, 1'b0, 1'b1));
      send_item(make_req(csm_pkg::CMD_NONZERO, csm_pkg::MAX_INDEX - 1, Q_MIN, 1'b1, 1'b0));
      send_item(make_req(csm_pkg::CMD_NONZERO, 0, Q_MAX, 1'b0, 1'b0));
      send_item(make_req(csm_pkg::CMD_NONZERO, 0, Q_MAX, 1'b0, 1'b0));
      send_item(make_req(csm_pkg::CMD_NONZERO, 0, Q_MAX, 1'b0, 1'b0));
      send_item(make_req(csm_pkg::CMD_NONZERO, 2, Q_MAX, 1'b1, 1'b1));
   endtask

   // Empty rows with both flag mixes, then single and multi-term rows.
   task automatic test_row_framing();
      send_item(make_req(csm_pkg::CMD_EMPTY_ROW, csm_pkg::MAX_INDEX - 1, Q_MAX, 1'b1, 1'b0));
      send_item(make_req(csm_pkg::CMD_EMPTY_ROW, 0, Q_MIN, 1'b0, 1'b1));
      send_item(make_req(csm_pkg::CMD_NONZERO, 1, Q_ONE, 1'b1, 1'b0));
      send_item(make_req(csm_pkg::CMD_NONZERO, csm_pkg::MAX_INDEX - 1, Q_MAX, 1'b1, 1'b1));
      send_item(make_req(csm_pkg::CMD_NONZERO, 10'h2AA, 32'hAAAA_AAAA, 1'b0, 1'b0));
      send_item(make_req(csm_pkg::CMD_NONZERO, 10'h155, 32'h5555_5555, 1'b1, 1'b0));
   endtask

   // The reserved command must leave the open row untouched.
   task automatic test_reserved_command();
      send_item(make_req(csm_pkg::CMD_NONZERO, 1, Q_MAX, 1'b0, 1'b0));
      send_item(make_req(CMD_RESERVED, csm_pkg::MAX_INDEX - 1, 32'hFFFF_FFFF, 1'b1, 1'b1));
      send_item(make_req(CMD_RESERVED, 0, 32'h0, 1'b0, 1'b0));
      send_item(make_req(csm_pkg::CMD_NONZERO, 0, Q_ONE, 1'b1, 1'b1));
   endtask

   task automatic test_random_matrices(input int item_goal);
      int start_count;
      int n_loads;
      int n_rows;
      int n_nz;
      bit lr;
      start_count = items_sent;
      while (items_sent - start_count < item_goal) begin
         n_loads = $urandom_range(1, 12);
         repeat (n_loads)
            send_item(make_req(csm_pkg::CMD_LOAD, $urandom_range(0, csm_pkg::MAX_INDEX - 1),
                               rand_operand(), $urandom_range(0, 1), $urandom_range(0, 1)));
         n_rows = $urandom_range(1, 6);
         for (int r = 0; r < n_rows; r++) begin
            n_nz = $urandom_range(0, 5);
            if (n_nz == 0)
               send_item(make_req(csm_pkg::CMD_EMPTY_ROW,
                                  $urandom_range(0, csm_pkg::MAX_INDEX - 1),
                                  rand_operand(), $urandom_range(0, 1), r == n_rows - 1));
            for (int k = 0; k < n_nz; k++) begin
               // inject noise now and then: reserved, stray row end, late load
               case ($urandom_range(0, 31))
                  0: send_item(make_req(CMD_RESERVED,
                                        $urandom_range(0, csm_pkg::MAX_INDEX - 1),
                                        $urandom, $urandom_range(0, 1), $urandom_range(0, 1)));
                  1: send_item(make_req(csm_pkg::CMD_EMPTY_ROW,
                                        $urandom_range(0, csm_pkg::MAX_INDEX - 1),
                                        rand_operand(), $urandom_range(0, 1), 1'b0));
                  2: send_item(make_req(csm_pkg::CMD_LOAD,
                                        $urandom_range(0, csm_pkg::MAX_INDEX - 1),
                                        rand_operand(), 1'b0, 1'b0));
                  default: ;
               endcase
               lr = (k == n_nz - 1) ? (r == n_rows - 1) : $urandom_range(0, 1);
               send_item(make_req(csm_pkg::CMD_NONZERO, pick_column(), rand_operand(),
                                  k == n_nz - 1, lr));
            end
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 32;
      recv_idle_pct = 75;
      test_vector_loads();
      test_saturation();
      test_row_framing();
      test_reserved_command();
      test_random_matrices(340);
      drain_results();

      send_idle_pct = 75;
      recv_idle_pct = 32;
      test_random_matrices(370);
      drain_results();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_matrices(370);
      drain_results();

      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+design
design/csm_pkg.sv
design/csm_vec_store.sv
design/csr_sparse_matvec.sv
tb/csr_sparse_matvec_test.sv
